### hw/rtl/lztbe_pkg.sv
// ----------------------------------------------------------------------------
// lztbe_pkg
// Shared types, codes and constants of the LZ token bitstream encoder.
// ----------------------------------------------------------------------------
package lztbe_pkg;

  // Token codes on the input channel
  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Format limits
  localparam int unsigned MAX_MATCH_LENGTH = 65536;
  localparam int unsigned OFFSET_LIMIT     = 2176;
  localparam int unsigned SHORT_OFF_LIMIT  = 128;
  localparam int unsigned HELD_DEPTH       = 8;
  localparam int unsigned END_ZERO_BITS    = 16;
  localparam int unsigned OFF_HI_BITS      = 4;

  // Controller states
  typedef enum logic [3:0] {
    CS_IDLE,
    CS_LEAD,
    CS_LIT,
    CS_GZERO,
    CS_GBITS,
    CS_OFFB,
    CS_OFFBITS,
    CS_EZERO,
    CS_ETAIL,
    CS_FLUSH
  } ctl_state_t;

  // Datapath operations, one per cycle
  typedef enum logic [1:0] {
    DP_NOP,
    DP_BIT,
    DP_BYTE,
    DP_DRAIN
  } dp_op_t;

  // Where a flag bit comes from
  typedef enum logic [1:0] {
    BS_ZERO,
    BS_ONE,
    BS_GAMMA,
    BS_OFFHI
  } bit_src_t;

  // Where a data byte comes from
  typedef enum logic {
    YS_LIT,
    YS_OFF
  } byte_src_t;

  typedef struct packed {
    dp_op_t    op;
    bit_src_t  bsrc;
    logic [3:0] bidx;
    byte_src_t ysrc;
    logic      last;
    logic      capture;
    logic      set_first;
  } dp_cmd_t;

  typedef struct packed {
    logic       pos_full;
    logic       pos_open;
    logic       out_free;
    logic       first_pending;
    logic       long_off;
    logic [3:0] gtop;
  } dp_stat_t;

  // Index of the highest set bit; zero for a zero word
  function automatic logic [3:0] msb_index(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

### hw/rtl/lztbe_in_if.sv
// ----------------------------------------------------------------------------
// lztbe_in_if
// Token channel: valid/ready handshake with one LZ token as payload.
// ----------------------------------------------------------------------------
interface lztbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  literal_value;
  logic [16:0] match_length;
  logic [11:0] match_offset;

  modport source (output valid, output token_kind, output literal_value,
                  output match_length, output match_offset, input ready);
  modport sink   (input valid, input token_kind, input literal_value,
                  input match_length, input match_offset, output ready);
endinterface

### hw/rtl/lztbe_out_if.sv
// ----------------------------------------------------------------------------
// lztbe_out_if
// Byte stream channel: valid/ready handshake with one stream byte as payload.
// ----------------------------------------------------------------------------
interface lztbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

### hw/rtl/lztbe_dp.sv
// ----------------------------------------------------------------------------
// lztbe_dp
// Datapath: token registers, open flag byte, held byte store and the output
// register. Executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module lztbe_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lztbe_pkg::dp_cmd_t cmd,
  output lztbe_pkg::dp_stat_t st,
  input  logic [1:0]         token_kind,
  input  logic [7:0]         literal_value,
  input  logic [16:0]        match_length,
  input  logic [11:0]        match_offset,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int unsigned HELD_DEPTH_L = lztbe_pkg::HELD_DEPTH;

  // Token registers (payload)
  logic [7:0]  lit_r;
  logic [15:0] gval_r;
  logic [3:0]  gtop_r;
  logic [7:0]  offb_r;
  logic [3:0]  offhi_r;
  logic        long_r;

  // Flag byte and held store
  logic       first_r, first_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] didx_r, didx_nxt;
  logic [7:0] held_r [HELD_DEPTH_L];

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  // Token decode at capture
  logic [16:0] len_sat;
  logic [15:0] gval_c;
  logic [11:0] off_sat;
  logic [11:0] o1;
  logic [11:0] o2;
  logic        long_c;

  always_comb begin
    if (match_length < 17'd2) begin
      len_sat = 17'd2;
    end else if (match_length > 17'(lztbe_pkg::MAX_MATCH_LENGTH)) begin
      len_sat = 17'(lztbe_pkg::MAX_MATCH_LENGTH);
    end else begin
      len_sat = match_length;
    end
    gval_c = 16'(len_sat - 17'd1);
    if (match_offset < 12'd1) begin
      off_sat = 12'd1;
    end else if (match_offset > 12'(lztbe_pkg::OFFSET_LIMIT)) begin
      off_sat = 12'(lztbe_pkg::OFFSET_LIMIT);
    end else begin
      off_sat = match_offset;
    end
    o1     = off_sat - 12'd1;
    o2     = o1 - 12'(lztbe_pkg::SHORT_OFF_LIMIT);
    long_c = (o1 >= 12'(lztbe_pkg::SHORT_OFF_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lit_r   <= literal_value;
      gval_r  <= gval_c;
      gtop_r  <= lztbe_pkg::msb_index(gval_c);
      offb_r  <= long_c ? {1'b1, o2[6:0]} : o1[7:0];
      offhi_r <= o2[10:7];
      long_r  <= long_c;
    end
  end

  // Operand selection
  logic       bit_val;
  logic [7:0] byte_val;
  logic       out_free;
  logic       drain_last;
  logic [7:0] drain_byte;
  logic       hold_wr;

  always_comb begin
    unique case (cmd.bsrc)
      lztbe_pkg::BS_ZERO:  bit_val = 1'b0;
      lztbe_pkg::BS_ONE:   bit_val = 1'b1;
      lztbe_pkg::BS_GAMMA: bit_val = gval_r[cmd.bidx];
      lztbe_pkg::BS_OFFHI: bit_val = offhi_r[cmd.bidx[1:0]];
      default:             bit_val = 1'b0;
    endcase
    byte_val   = (cmd.ysrc == lztbe_pkg::YS_OFF) ? offb_r : lit_r;
    out_free   = !out_valid_r || out_ready;
    drain_last = (didx_r == cnt_r);
    drain_byte = (didx_r == 4'd0) ? flag_r : held_r[3'(didx_r - 4'd1)];
    hold_wr    = (cmd.op == lztbe_pkg::DP_BYTE) && (pos_r != 4'd0)
                 && (cnt_r < 4'(HELD_DEPTH_L));
  end

  // Next state of flag byte, store and output register
  always_comb begin
    first_nxt     = first_r;
    flag_nxt      = flag_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cmd.capture && (token_kind == lztbe_pkg::KIND_LIT ||
                        token_kind == lztbe_pkg::KIND_MATCH)) begin
      first_nxt = 1'b0;
    end
    if (cmd.set_first) first_nxt = 1'b1;

    unique case (cmd.op)
      lztbe_pkg::DP_BIT: begin
        if (bit_val) flag_nxt = flag_r | (8'h80 >> pos_r[2:0]);
        pos_nxt = pos_r + 4'd1;
      end
      lztbe_pkg::DP_BYTE: begin
        if (hold_wr) begin
          cnt_nxt = cnt_r + 4'd1;
        end else if (pos_r == 4'd0) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_val;
          out_last_nxt  = 1'b0;
        end
      end
      lztbe_pkg::DP_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = drain_byte;
        out_last_nxt  = cmd.last && drain_last;
        if (drain_last) begin
          flag_nxt = '0;
          pos_nxt  = '0;
          cnt_nxt  = '0;
          didx_nxt = '0;
        end else begin
          didx_nxt = didx_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      flag_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      didx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      flag_r      <= flag_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      didx_r      <= didx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (hold_wr) held_r[cnt_r[2:0]] <= byte_val;
  end

  // Status and outputs
  assign st.pos_full      = (pos_r == 4'd8);
  assign st.pos_open      = (pos_r != 4'd0);
  assign st.out_free      = out_free;
  assign st.first_pending = first_r;
  assign st.long_off      = long_r;
  assign st.gtop          = gtop_r;

  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

  // A flag bit is never written into a full flag byte
  a_bit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == lztbe_pkg::DP_BIT |-> pos_r != 4'd8)
    else $error("flag bit written into full flag byte");

  // Anything sent to the output register finds the slot free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == lztbe_pkg::DP_DRAIN ||
     (cmd.op == lztbe_pkg::DP_BYTE && pos_r == 4'd0)) |-> out_free)
    else $error("byte emitted over a pending output");

  // The last drain step closes the flag byte and empties the store
  a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == lztbe_pkg::DP_DRAIN && drain_last) |=>
      (pos_r == 4'd0 && cnt_r == 4'd0 && didx_r == 4'd0))
    else $error("flag byte not closed after drain");

  // A held byte always finds room in the store
  a_held_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == lztbe_pkg::DP_BYTE && pos_r != 4'd0) |->
      cnt_r < 4'(HELD_DEPTH_L))
    else $error("held byte store overflow");

endmodule

### hw/rtl/lztbe_ctrl.sv
// ----------------------------------------------------------------------------
// lztbe_ctrl
// Controller: sequences each token into flag bit, byte and drain operations
// for the datapath, at most one operation per cycle; byte and drain steps wait for a free output.
// ----------------------------------------------------------------------------
module lztbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          token_kind,
  output logic                in_ready,
  input  lztbe_pkg::dp_stat_t st,
  output lztbe_pkg::dp_cmd_t  cmd
);

  lztbe_pkg::ctl_state_t state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lztbe_pkg::CS_IDLE;
      k_r     <= '0;
      kind_r  <= lztbe_pkg::KIND_LIT;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    in_ready  = 1'b0;

    if (state_r != lztbe_pkg::CS_FLUSH && st.pos_full) begin
      // Flag byte complete: send it and its held bytes first
      if (st.out_free) cmd.op = lztbe_pkg::DP_DRAIN;
    end else begin
      unique case (state_r)
        lztbe_pkg::CS_IDLE: begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            kind_nxt    = token_kind;
            if (token_kind == lztbe_pkg::KIND_LIT) begin
              state_nxt = st.first_pending ? lztbe_pkg::CS_LIT : lztbe_pkg::CS_LEAD;
            end else if (token_kind == lztbe_pkg::KIND_MATCH ||
                         token_kind == lztbe_pkg::KIND_END) begin
              state_nxt = lztbe_pkg::CS_LEAD;
            end
          end
        end
        lztbe_pkg::CS_LEAD: begin
          cmd.op   = lztbe_pkg::DP_BIT;
          cmd.bsrc = (kind_r == lztbe_pkg::KIND_LIT) ? lztbe_pkg::BS_ZERO
                                                     : lztbe_pkg::BS_ONE;
          if (kind_r == lztbe_pkg::KIND_LIT) begin
            state_nxt = lztbe_pkg::CS_LIT;
          end else if (kind_r == lztbe_pkg::KIND_MATCH) begin
            if (st.gtop == 4'd0) begin
              state_nxt = lztbe_pkg::CS_GBITS;
              k_nxt     = 4'd0;
            end else begin
              state_nxt = lztbe_pkg::CS_GZERO;
              k_nxt     = st.gtop - 4'd1;
            end
          end else begin
            state_nxt = lztbe_pkg::CS_EZERO;
            k_nxt     = 4'(lztbe_pkg::END_ZERO_BITS - 1);
          end
        end
        lztbe_pkg::CS_LIT: begin
          if (st.out_free) begin
            cmd.op    = lztbe_pkg::DP_BYTE;
            cmd.ysrc  = lztbe_pkg::YS_LIT;
            state_nxt = lztbe_pkg::CS_IDLE;
          end
        end
        // Gamma prefix: one zero per bit below the top one
        lztbe_pkg::CS_GZERO: begin
          cmd.op   = lztbe_pkg::DP_BIT;
          cmd.bsrc = lztbe_pkg::BS_ZERO;
          if (k_r == 4'd0) begin
            state_nxt = lztbe_pkg::CS_GBITS;
            k_nxt     = st.gtop;
          end else begin
            k_nxt = k_r - 4'd1;
          end
        end
        // Gamma body, MSB first
        lztbe_pkg::CS_GBITS: begin
          cmd.op   = lztbe_pkg::DP_BIT;
          cmd.bsrc = lztbe_pkg::BS_GAMMA;
          cmd.bidx = k_r;
          if (k_r == 4'd0) state_nxt = lztbe_pkg::CS_OFFB;
          else             k_nxt     = k_r - 4'd1;
        end
        lztbe_pkg::CS_OFFB: begin
          if (st.out_free) begin
            cmd.op   = lztbe_pkg::DP_BYTE;
            cmd.ysrc = lztbe_pkg::YS_OFF;
            if (st.long_off) begin
              state_nxt = lztbe_pkg::CS_OFFBITS;
              k_nxt     = 4'(lztbe_pkg::OFF_HI_BITS - 1);
            end else begin
              state_nxt = lztbe_pkg::CS_IDLE;
            end
          end
        end
        // High offset bits of a long offset
        lztbe_pkg::CS_OFFBITS: begin
          cmd.op   = lztbe_pkg::DP_BIT;
          cmd.bsrc = lztbe_pkg::BS_OFFHI;
          cmd.bidx = k_r;
          if (k_r == 4'd0) state_nxt = lztbe_pkg::CS_IDLE;
          else             k_nxt     = k_r - 4'd1;
        end
        // End marker: zeros, then the closing one
        lztbe_pkg::CS_EZERO: begin
          cmd.op   = lztbe_pkg::DP_BIT;
          cmd.bsrc = lztbe_pkg::BS_ZERO;
          if (k_r == 4'd0) state_nxt = lztbe_pkg::CS_ETAIL;
          else             k_nxt     = k_r - 4'd1;
        end
        lztbe_pkg::CS_ETAIL: begin
          cmd.op    = lztbe_pkg::DP_BIT;
          cmd.bsrc  = lztbe_pkg::BS_ONE;
          state_nxt = lztbe_pkg::CS_FLUSH;
        end
        // Flush the open flag byte; its final byte closes the stream
        lztbe_pkg::CS_FLUSH: begin
          if (st.pos_open) begin
            if (st.out_free) begin
              cmd.op   = lztbe_pkg::DP_DRAIN;
              cmd.last = 1'b1;
            end
          end else begin
            cmd.set_first = 1'b1;
            state_nxt     = lztbe_pkg::CS_IDLE;
          end
        end
        default: state_nxt = lztbe_pkg::CS_IDLE;
      endcase
    end
  end

  // Tokens are taken only with no complete flag byte pending
  a_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == lztbe_pkg::CS_IDLE && !st.pos_full))
    else $error("token taken with pending flag byte");

  // A flushed stream always comes back to idle
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lztbe_pkg::CS_FLUSH && !st.pos_open) |=>
      state_r == lztbe_pkg::CS_IDLE)
    else $error("flush did not return to idle");

  // Only the flush marks a byte as last
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |-> (state_r == lztbe_pkg::CS_FLUSH && cmd.op == lztbe_pkg::DP_DRAIN))
    else $error("last mark outside flush");

endmodule

### hw/rtl/lz_token_bitstream_encoder.sv
// A raw first literal leaves through the CS_LIT state and the output register. A byte
// written while a flag byte is open is held and follows that flag byte, which drains
// when its 8th bit is in and the output is free; other bytes go straight out. The
// sequencer handles each flag bit and byte of a token in turn before taking the next.
// Output stalls hold the sequencer on byte and drain steps only.
// Reset (rst_n low, synchronous): flag byte closed, no output, first-token flag set.
// ----------------------------------------------------------------------------
// lz_token_bitstream_encoder
// Turns a stream of LZ tokens (literal, match, end) into the ZX7 byte stream.
// ----------------------------------------------------------------------------
module lz_token_bitstream_encoder (
  input  logic         clk,
  input  logic         rst_n,
  lztbe_in_if.sink     in_tok,
  lztbe_out_if.source  out_str
);

  lztbe_pkg::dp_cmd_t  cmd;
  lztbe_pkg::dp_stat_t st;

  // Token sequencer
  lztbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tok.valid),
    .token_kind (in_tok.token_kind),
    .in_ready   (in_tok.ready),
    .st         (st),
    .cmd        (cmd)
  );

  // Flag byte, held bytes and output register
  lztbe_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .token_kind    (in_tok.token_kind),
    .literal_value (in_tok.literal_value),
    .match_length  (in_tok.match_length),
    .match_offset  (in_tok.match_offset),
    .out_byte      (out_str.out_byte),
    .out_last      (out_str.last_byte),
    .out_valid     (out_str.valid),
    .out_ready     (out_str.ready)
  );

endmodule
